// ===== sv/arl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arl_pkg
// Shared types and constants for the stereo retrigger looper.
// ----------------------------------------------------------------------------
package arl_pkg;

  localparam int MAX_LOOP    = 65536;
  localparam int ADDR_W      = $clog2(MAX_LOOP);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAME_W     = 2 * SAMPLE_BITS;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLE_LEN = 2'd0,
    CFG_GATE_LEN  = 2'd1
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] CYCLE_LEN_RST = 17'd24000;
  localparam logic [CFG_DATA_W-1:0] GATE_LEN_RST  = 17'd12000;

  // 0.0125 in Q0.24, rounded to nearest
  localparam int ATTEN_COEF_W = 19;
  localparam logic signed [ATTEN_COEF_W-1:0] ATTEN_COEF = 19'sd209715;
  localparam int ATTEN_SHIFT = 24;
  localparam int PROD_W      = SAMPLE_BITS + ATTEN_COEF_W;

  // Frame in flight between the RAM read and the output register
  typedef struct packed {
    logic                   valid;
    logic                   replay;  // position within gate: use loop data
    logic                   fwd;     // same frame written at the read address
    logic                   blank;   // address never written since reset
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } stage_t;

endpackage : arl_pkg
`default_nettype wire

// ===== sv/arl_loop_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arl_loop_ram
// Loop store: one write port, one registered read port, stereo frame wide.
// ----------------------------------------------------------------------------
module arl_loop_ram (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [arl_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [arl_pkg::FRAME_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [arl_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [arl_pkg::FRAME_W-1:0] rd_data
);

  logic [arl_pkg::FRAME_W-1:0] mem [0:arl_pkg::MAX_LOOP-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : arl_loop_ram
`default_nettype wire

// ===== sv/arl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arl_ctrl
// Capture and play counters, fill mark, RAM access issue, config registers.
// ----------------------------------------------------------------------------
module arl_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [arl_pkg::SAMPLE_BITS-1:0]  left_in,
  input  wire logic [arl_pkg::SAMPLE_BITS-1:0]  right_in,
  input  wire logic                             restart,
  input  wire logic                             cfg_valid,
  input  wire logic [arl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [arl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             stage_adv,
  output arl_pkg::stage_t                       stage,
  output logic                                  wr_en,
  output logic      [arl_pkg::ADDR_W-1:0]       wr_addr,
  output logic      [arl_pkg::FRAME_W-1:0]      wr_data,
  output logic                                  rd_en,
  output logic      [arl_pkg::ADDR_W-1:0]       rd_addr
);

  localparam int CW = arl_pkg::CNT_W;
  localparam int AW = arl_pkg::ADDR_W;

  logic [arl_pkg::CFG_DATA_W-1:0] cycle_len;
  logic [arl_pkg::CFG_DATA_W-1:0] gate_len;
  logic [CW-1:0] cap_idx;
  logic [AW-1:0] play_pos;
  logic [CW-1:0] fill_mark;  // entries below this were written since reset

  logic          accept;
  logic [CW-1:0] cyc_eff;
  logic [CW-1:0] cap_cur;
  logic [AW-1:0] pos_cur;
  logic [AW-1:0] pos_eff;
  logic [CW-1:0] pos_inc;
  logic          cap_go;

  assign in_ready = !stage.valid || stage_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (cycle_len == '0) begin
      cyc_eff = CW'(1);
    end else if (CW'(cycle_len) > CW'(arl_pkg::MAX_LOOP)) begin
      cyc_eff = CW'(arl_pkg::MAX_LOOP);
    end else begin
      cyc_eff = CW'(cycle_len);
    end
  end

  always_comb begin
    cap_cur = restart ? '0 : cap_idx;
    pos_cur = restart ? '0 : play_pos;
    pos_eff = ({1'b0, pos_cur} >= cyc_eff) ? '0 : pos_cur;
    pos_inc = {1'b0, pos_eff} + CW'(1);
    cap_go  = cap_cur < cyc_eff;
  end

  assign wr_en   = accept && cap_go;
  assign wr_addr = cap_cur[AW-1:0];
  assign wr_data = {left_in, right_in};
  assign rd_en   = accept;
  assign rd_addr = pos_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_len <= arl_pkg::CYCLE_LEN_RST;
      gate_len  <= arl_pkg::GATE_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        arl_pkg::CFG_CYCLE_LEN: cycle_len <= cfg_data;
        arl_pkg::CFG_GATE_LEN:  gate_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_idx   <= '0;
      play_pos  <= '0;
      fill_mark <= '0;
    end else if (accept) begin
      play_pos <= (pos_inc >= cyc_eff) ? '0 : pos_inc[AW-1:0];
      if (cap_go) begin
        cap_idx <= cap_cur + CW'(1);
        if (cap_cur >= fill_mark) begin
          fill_mark <= cap_cur + CW'(1);
        end
      end else begin
        cap_idx <= cap_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_ready) begin
      stage.valid <= in_valid;
    end
    if (accept) begin
      stage.replay <= CW'(pos_eff) <= CW'(gate_len);
      stage.fwd    <= cap_go && (cap_cur == CW'(pos_eff));
      stage.blank  <= CW'(pos_eff) >= fill_mark;
      stage.left   <= left_in;
      stage.right  <= right_in;
    end
  end

endmodule : arl_ctrl
`default_nettype wire

// ===== sv/arl_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arl_mix
// Picks loop data or attenuated live input and holds the result beat.
// ----------------------------------------------------------------------------
module arl_mix (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire arl_pkg::stage_t                  stage,
  input  wire logic [arl_pkg::FRAME_W-1:0]      rd_data,
  output logic                                  stage_adv,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [arl_pkg::SAMPLE_BITS-1:0]  left_out,
  output logic      [arl_pkg::SAMPLE_BITS-1:0]  right_out
);

  localparam int SB = arl_pkg::SAMPLE_BITS;
  localparam int PW = arl_pkg::PROD_W;
  localparam int QW = PW - arl_pkg::ATTEN_SHIFT;

  logic signed [PW-1:0] prod_l, prod_r;
  logic signed [PW-1:0] rnd_l, rnd_r;
  logic signed [QW-1:0] q_l, q_r;
  logic [SB-1:0] att_l, att_r;
  logic [SB-1:0] loop_l, loop_r;
  logic [SB-1:0] left_next, right_next;

  assign stage_adv = !out_valid || out_ready;

  // round half up, then floor shift; result always fits the sample width
  always_comb begin
    prod_l = $signed(stage.left)  * arl_pkg::ATTEN_COEF;
    prod_r = $signed(stage.right) * arl_pkg::ATTEN_COEF;
    rnd_l  = prod_l + PW'(1 << (arl_pkg::ATTEN_SHIFT - 1));
    rnd_r  = prod_r + PW'(1 << (arl_pkg::ATTEN_SHIFT - 1));
    q_l    = rnd_l[PW-1:arl_pkg::ATTEN_SHIFT];
    q_r    = rnd_r[PW-1:arl_pkg::ATTEN_SHIFT];
    att_l  = SB'(q_l);
    att_r  = SB'(q_r);
  end

  always_comb begin
    if (stage.fwd) begin
      loop_l = stage.left;
      loop_r = stage.right;
    end else if (stage.blank) begin
      loop_l = '0;
      loop_r = '0;
    end else begin
      loop_l = rd_data[2*SB-1:SB];
      loop_r = rd_data[SB-1:0];
    end
    left_next  = stage.replay ? loop_l : att_l;
    right_next = stage.replay ? loop_r : att_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage.valid) begin
      left_out  <= left_next;
      right_out <= right_next;
    end
  end

endmodule : arl_mix
`default_nettype wire

// ===== sv/audio_retrigger_looper_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_retrigger_looper_top
// Stereo retrigger effect: captures a loop after restart and replays it.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------
//   in      | sink      | in_valid / in_ready   | left_in, right_in, restart
//   out     | source    | out_valid / out_ready | left_out, right_out
//   cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One frame per cycle while out_ready holds; a frame goes RAM read, then output reg.
// The single-port-write, single-port-read loop RAM sets the rate: one write
// and one read per frame. A fill mark stands in for clearing the RAM, so the
// block takes frames as soon as reset is released. A stalled output
// holds the pipeline; in_ready follows out_ready through one stage.
// ----------------------------------------------------------------------------
module audio_retrigger_looper_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [arl_pkg::SAMPLE_BITS-1:0]  left_in,
  input  wire logic [arl_pkg::SAMPLE_BITS-1:0]  right_in,
  input  wire logic                             restart,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [arl_pkg::SAMPLE_BITS-1:0]  left_out,
  output logic      [arl_pkg::SAMPLE_BITS-1:0]  right_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [arl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [arl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  arl_pkg::stage_t               stage;
  logic                          stage_adv;
  logic                          wr_en;
  logic [arl_pkg::ADDR_W-1:0]    wr_addr;
  logic [arl_pkg::FRAME_W-1:0]   wr_data;
  logic                          rd_en;
  logic [arl_pkg::ADDR_W-1:0]    rd_addr;
  logic [arl_pkg::FRAME_W-1:0]   rd_data;

  assign cfg_ready = 1'b1;

  arl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .restart   (restart),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage_adv (stage_adv),
    .stage     (stage),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  arl_loop_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  arl_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .rd_data   (rd_data),
    .stage_adv (stage_adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule : audio_retrigger_looper_top
`default_nettype wire

// ===== bench/retrigger_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retrigger_checker
// Watches the cfg, in and out channels of the retrigger looper. It keeps
// its own loop store, capture/play counters and register copies, works out
// the stereo frame due for every input beat, and compares each output beat
// field by field against the oldest frame due.
// ----------------------------------------------------------------------------
module retrigger_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [arl_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic [arl_pkg::SAMPLE_BITS-1:0] right_in,
  input  logic                            restart,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [arl_pkg::SAMPLE_BITS-1:0] left_out,
  input  logic [arl_pkg::SAMPLE_BITS-1:0] right_out,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [arl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              frames_due
);
  import arl_pkg::*;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } stereo_t;

  logic [SAMPLE_BITS-1:0] store_l [MAX_LOOP];
  logic [SAMPLE_BITS-1:0] store_r [MAX_LOOP];
  int                     capture_at;
  int                     play_at;
  logic [CFG_DATA_W-1:0]  cycle_reg;
  logic [CFG_DATA_W-1:0]  gate_reg;
  stereo_t                frames_q [$];
  int                     mismatches = 0;
  int                     due = 0;

  assign fail_count = mismatches;
  assign frames_due = due;

  // live path: x * 0.0125 in Q0.24, round half up
  function automatic logic [SAMPLE_BITS-1:0] scale_live(logic [SAMPLE_BITS-1:0] x);
    longint prod;
    prod = longint'(signed'(x)) * longint'(ATTEN_COEF);
    prod = (prod + (longint'(1) <<< (ATTEN_SHIFT - 1))) >>> ATTEN_SHIFT;
    return prod[SAMPLE_BITS-1:0];
  endfunction

  // advance the loop by one frame and return the frame it plays
  function automatic stereo_t loop_frame(logic [SAMPLE_BITS-1:0] l,
                                         logic [SAMPLE_BITS-1:0] r, logic rs);
    int      span;
    int      pos;
    stereo_t y;
    if (cycle_reg == '0)
      span = 1;
    else if (int'(cycle_reg) > MAX_LOOP)
      span = MAX_LOOP;
    else
      span = int'(cycle_reg);
    if (rs) begin
      capture_at = 0;
      play_at    = 0;
    end
    if (play_at >= span)
      play_at = 0;
    pos = play_at;
    // capture first, so a write at pos is seen by this frame's read
    if (capture_at < span) begin
      store_l[capture_at] = l;
      store_r[capture_at] = r;
      capture_at++;
    end
    if (pos <= int'(gate_reg)) begin
      y.left  = store_l[pos];
      y.right = store_r[pos];
    end else begin
      y.left  = scale_live(l);
      y.right = scale_live(r);
    end
    play_at = (pos + 1 >= span) ? 0 : pos + 1;
    return y;
  endfunction

  task automatic report(string what, logic [SAMPLE_BITS-1:0] exp_v,
                        logic [SAMPLE_BITS-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    stereo_t exp_f;
    if (rst) begin
      for (int i = 0; i < MAX_LOOP; i++) begin
        store_l[i] = '0;
        store_r[i] = '0;
      end
      capture_at = 0;
      play_at    = 0;
      cycle_reg  = CYCLE_LEN_RST;
      gate_reg   = GATE_LEN_RST;
      frames_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CYCLE_LEN: cycle_reg = cfg_data;
          CFG_GATE_LEN:  gate_reg  = cfg_data;
          default: ;
        endcase
      end
      // an output beat never comes from an input taken at the same edge: check before predicting
      if (out_valid && out_ready) begin
        if (frames_q.size() == 0) begin
          report("unexpected out beat, left_out", 'x, left_out);
        end else begin
          exp_f = frames_q.pop_front();
          if (left_out !== exp_f.left)
            report("left_out", exp_f.left, left_out);
          if (right_out !== exp_f.right)
            report("right_out", exp_f.right, right_out);
        end
      end
      if (in_valid && in_ready)
        frames_q.push_back(loop_frame(left_in, right_in, restart));
    end
    due = frames_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the stereo retrigger looper. Directed frames at
// the sample extremes, then random frames over a series of loop/gate
// settings with random restarts, random idling on both channels and one
// long output hold-off. Checking is done by retrigger_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import arl_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_PHASES    = 11;
  localparam int QUIET_PHASE = 6;
  localparam int HOLD_PHASE  = 9;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] left_in   = '0;
  logic [SAMPLE_BITS-1:0] right_in  = '0;
  logic                   restart   = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] left_out;
  logic [SAMPLE_BITS-1:0] right_out;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int fail_count;
  int frames_due;
  int idle_run    = 0;
  int holds_asked = 0;
  int holds_done  = 0;
  bit quiet       = 1'b0;

  // shrink 200 -> 40 mid-loop, grow 8 -> 24 after capture, clamps at both ends
  int phase_cycle [N_PHASES] = '{8, 24, 200, 40, 1, 0, 16, 131071, 65536, 300, 5};
  int phase_gate  [N_PHASES] = '{3, 10, 50, 131071, 0, 0, 16, 131071, 0, 299, 2};
  int phase_beats [N_PHASES] = '{100, 100, 150, 100, 40, 40, 100, 100, 100, 200, 80};

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  audio_retrigger_looper_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  retrigger_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .left_in    (left_in),
    .right_in   (right_in),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .left_out   (left_out),
    .right_out  (right_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .frames_due (frames_due)
  );

  // output side: random stalls, or a long hold-off when one is asked for
  initial begin
    forever begin
      @(negedge clk);
      if (holds_done < holds_asked) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_frame(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                            logic rs);
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // drain the pipe, then load both registers and poke an unused index
  task automatic set_loop(int cyc, int gate);
    in_valid <= 1'b0;
    while (frames_due != 0) @(negedge clk);
    write_reg(CFG_CYCLE_LEN, CFG_DATA_W'(cyc));
    write_reg(CFG_GATE_LEN, CFG_DATA_W'(gate));
    write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // short loop, gate covers positions 0 and 1, rest is live attenuated
    set_loop(4, 1);
    send_frame(24'h7FFFFF, 24'h800000, 1'b1);
    send_frame(24'h800000, 24'h7FFFFF, 1'b0);
    send_frame(24'h000000, 24'hFFFFFF, 1'b0);
    send_frame(24'hFFFFFF, 24'h000000, 1'b0);
    send_frame(24'd40, -24'sd40, 1'b0);
    send_frame(24'd80, -24'sd80, 1'b0);
    send_frame(24'h7FFFFF, 24'h800000, 1'b0);
    send_frame(24'h800000, 24'h7FFFFF, 1'b0);
    send_frame(24'h000028, 24'hFFFFD8, 1'b0);
    send_frame(24'h5A5A5A, 24'hA5A5A5, 1'b1);
    // zero cycle length acts as one
    set_loop(0, 0);
    @(negedge clk);
    write_reg(CFG_SPARE_2, '1);
    write_reg(CFG_SPARE_3, '0);
    cfg_valid <= 1'b0;
    send_frame(24'd123, 24'd456, 1'b1);
    send_frame(24'd7, 24'd8, 1'b0);
    send_frame(24'hFFFFFF, 24'h800000, 1'b0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_loop(phase_cycle[ph], phase_gate[ph]);
      quiet = (ph == QUIET_PHASE);
      if (ph == HOLD_PHASE)
        holds_asked++;
      for (int k = 0; k < phase_beats[ph]; k++)
        send_frame(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                   $urandom_range(39) == 0);
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (frames_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== audio_retrigger_looper_top.f =====
sv/arl_pkg.sv
sv/arl_loop_ram.sv
sv/arl_ctrl.sv
sv/arl_mix.sv
sv/audio_retrigger_looper_top.sv
bench/retrigger_checker.sv
bench/tb_top.sv
